// File: rtl/core/rir_pkg.sv
package rir_pkg;

   // configuration port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;
   localparam int CFG_W  = 9;

   // register indexes
   localparam logic REG_SRC_WIDTH  = 1'b0;
   localparam logic REG_SRC_HEIGHT = 1'b1;

   // reset value of both dimension registers
   localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

   // pixel layout
   localparam int CHANNELS = 4;
   localparam int CH_W     = 8;
   localparam int PIX_W    = CHANNELS * CH_W;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EMIT = 1'b1;

   typedef struct packed {
      logic            kind;
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
      logic [CH_W-1:0] alpha_in;
   } req_payload_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic [CH_W-1:0] alpha_out;
      logic            frame_end;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_SIZE,
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_HOLD
   } state_type;

endpackage

// File: rtl/core/rir_req_if.sv
interface rir_req_if;
   logic                     valid;
   logic                     ready;
   rir_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/rir_rsp_if.sv
interface rir_rsp_if;
   logic                     valid;
   logic                     ready;
   rir_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/rgba_image_rotate_cw.sv
// Load items may follow each other in every cycle while the block is idle.
// Emit items pass a registered read of the pixel and valid stores, then the output register.
// An emit stalls while the previous result still waits for its transfer; input is held off.
// Reset is synchronous, active high; after reset and after every register write
// a clearing pass drops the valid marks of all W*H frame entries.
module rgba_image_rotate_cw #(
   parameter int MAX_DIM = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   rir_req_if.sink                    req,
   rir_rsp_if.source                  rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rir_pkg::ADDR_W-1:0] paddr,
   input  logic [rir_pkg::DATA_W-1:0] pwdata,
   output logic [rir_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import rir_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   logic [DIM_W-1:0] dim_w;
   logic [DIM_W-1:0] dim_h;
   logic             restart;

   logic             pix_wr_en;
   logic [AW-1:0]    pix_wr_addr;
   logic [PIX_W-1:0] pix_wr_data;
   logic [PIX_W-1:0] pix_rd_data;
   logic             vld_wr_en;
   logic [AW-1:0]    vld_wr_addr;
   logic             vld_wr_data;
   logic             vld_rd_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;

   rir_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .dim_w   (dim_w),
      .dim_h   (dim_h),
      .restart (restart)
   );

   rir_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .dim_w       (dim_w),
      .dim_h       (dim_h),
      .restart     (restart),
      .req         (req),
      .rsp         (rsp),
      .pix_wr_en   (pix_wr_en),
      .pix_wr_addr (pix_wr_addr),
      .pix_wr_data (pix_wr_data),
      .pix_rd_data (pix_rd_data),
      .vld_wr_en   (vld_wr_en),
      .vld_wr_addr (vld_wr_addr),
      .vld_wr_data (vld_wr_data),
      .vld_rd_data (vld_rd_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr)
   );

   // rotated frame store
   rir_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_pix_ram (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr (pix_wr_addr),
      .wr_data (pix_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (pix_rd_data)
   );

   // one valid mark per entry
   rir_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_vld_ram (
      .clock   (clock),
      .wr_en   (vld_wr_en),
      .wr_addr (vld_wr_addr),
      .wr_data (vld_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (vld_rd_data)
   );

endmodule

// File: rtl/core/rir_ram.sv
module rir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/rir_csr.sv
module rir_csr #(
   parameter int MAX_DIM = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rir_pkg::ADDR_W-1:0]   paddr,
   input  logic [rir_pkg::DATA_W-1:0]   pwdata,
   output logic [rir_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output logic [$clog2(MAX_DIM+1)-1:0] dim_w,
   output logic [$clog2(MAX_DIM+1)-1:0] dim_h,
   output logic                         restart
);
   import rir_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             wr_hit;

   // saturate a register value into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   assign pready = 1'b1;
   assign wr_hit = psel & penable & pwrite & pready;

   // decode writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_hit) begin
         unique case (paddr[2])
            REG_SRC_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            REG_SRC_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default:        width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // read back
   always_comb begin
      unique case (paddr[2])
         REG_SRC_WIDTH:  prdata = DATA_W'(width_ff);
         REG_SRC_HEIGHT: prdata = DATA_W'(height_ff);
         default:        prdata = '0;
      endcase
   end

   assign dim_w   = clamp_dim(width_ff);
   assign dim_h   = clamp_dim(height_ff);
   assign restart = wr_hit;

endmodule

// File: rtl/core/rir_ctrl.sv
module rir_ctrl #(
   parameter int MAX_DIM = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [$clog2(MAX_DIM+1)-1:0]           dim_w,
   input  logic [$clog2(MAX_DIM+1)-1:0]           dim_h,
   input  logic                                   restart,
   rir_req_if.sink                                req,
   rir_rsp_if.source                              rsp,
   output logic                                   pix_wr_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     pix_wr_addr,
   output logic [rir_pkg::PIX_W-1:0]              pix_wr_data,
   input  logic [rir_pkg::PIX_W-1:0]              pix_rd_data,
   output logic                                   vld_wr_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     vld_wr_addr,
   output logic                                   vld_wr_data,
   input  logic                                   vld_rd_data,
   output logic                                   mem_rd_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     mem_rd_addr
);
   import rir_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CW    = $clog2(MAX_DIM);
   localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
   localparam int PW    = 2 * DIM_W;

   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   last_ff, last_in;
   logic [CW-1:0]   load_col_ff, load_col_in;
   logic [CW-1:0]   load_row_ff, load_row_in;
   logic [AW-1:0]   load_addr_ff, load_addr_in;
   logic [AW-1:0]   emit_pos_ff, emit_pos_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            is_load;
   logic            is_emit;
   logic            slot_free;
   logic            emit_done;
   logic            clear_wr;
   logic            frame_end;
   logic [PW-1:0]   prod;
   logic [PW-1:0]   prod_m1;
   logic [DIM_W-1:0] w_m1;
   logic [DIM_W-1:0] h_m1;
   logic [DIM_W-1:0] row_next_addr;

   // frame size, last raster index
   assign prod    = PW'(dim_w) * PW'(dim_h);
   assign prod_m1 = prod - PW'(1);
   assign last_in = prod_m1[AW-1:0];

   assign w_m1          = dim_w - DIM_W'(1);
   assign h_m1          = dim_h - DIM_W'(1);
   assign row_next_addr = dim_h - DIM_W'(load_row_ff) - DIM_W'(2);

   // input handshake
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid & req.ready;
   assign is_load   = accept & (req.data.kind == KIND_LOAD);
   assign is_emit   = accept & (req.data.kind == KIND_EMIT);
   assign slot_free = ~rsp_valid_ff | rsp.ready;
   assign frame_end = (emit_pos_ff == last_ff);

   // next state and memory control
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      emit_done = 1'b0;
      clear_wr  = 1'b0;
      unique case (state_ff)
         ST_SIZE: begin
            clr_in   = '0;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            clear_wr = 1'b1;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == last_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (is_emit) begin
               state_in = ST_READ;
            end
         end
         ST_READ, ST_HOLD: begin
            if (!vld_rd_data) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               emit_done = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         default: state_in = ST_SIZE;
      endcase
      if (restart) begin
         state_in = ST_SIZE;
      end
   end

   // pixel store: written by loads
   assign pix_wr_en   = is_load;
   assign pix_wr_addr = load_addr_ff;
   assign pix_wr_data = {req.data.red_in, req.data.green_in,
                         req.data.blue_in, req.data.alpha_in};

   // valid store: set by loads, dropped by emits and the clearing pass
   assign vld_wr_en   = is_load | emit_done | clear_wr;
   assign vld_wr_data = is_load;
   assign vld_wr_addr = is_load ? load_addr_ff : (clear_wr ? clr_ff : emit_pos_ff);

   assign mem_rd_en   = is_emit;
   assign mem_rd_addr = emit_pos_ff;

   // load and emit positions
   always_comb begin
      load_col_in  = load_col_ff;
      load_row_in  = load_row_ff;
      load_addr_in = load_addr_ff;
      emit_pos_in  = emit_pos_ff;
      if (state_ff == ST_SIZE || state_ff == ST_CLEAR) begin
         load_col_in  = '0;
         load_row_in  = '0;
         load_addr_in = AW'(h_m1);
         emit_pos_in  = '0;
      end else begin
         if (is_load) begin
            if (DIM_W'(load_col_ff) == w_m1) begin
               load_col_in = '0;
               if (DIM_W'(load_row_ff) == h_m1) begin
                  load_row_in  = '0;
                  load_addr_in = AW'(h_m1);
               end else begin
                  load_row_in  = load_row_ff + CW'(1);
                  load_addr_in = AW'(row_next_addr);
               end
            end else begin
               load_col_in  = load_col_ff + CW'(1);
               load_addr_in = load_addr_ff + AW'(dim_h);
            end
         end
         if (emit_done) begin
            emit_pos_in = frame_end ? '0 : emit_pos_ff + AW'(1);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_data_in  = rsp_data_ff;
      if (emit_done) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.red_out   = pix_rd_data[4*CH_W-1:3*CH_W];
         rsp_data_in.green_out = pix_rd_data[3*CH_W-1:2*CH_W];
         rsp_data_in.blue_out  = pix_rd_data[2*CH_W-1:CH_W];
         rsp_data_in.alpha_out = pix_rd_data[CH_W-1:0];
         rsp_data_in.frame_end = frame_end;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SIZE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff       <= clr_in;
      last_ff      <= last_in;
      load_col_ff  <= load_col_in;
      load_row_ff  <= load_row_in;
      load_addr_ff <= load_addr_in;
      emit_pos_ff  <= emit_pos_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
